// ===== design/estc_pkg.sv =====
// estc_pkg: shared constants, types and helpers for epoch_seconds_to_calendar
// no dependencies
package estc_pkg;

  localparam int unsigned SecsW    = 32;
  localparam int unsigned DaysW    = 16;  // max day count 49710
  localparam int unsigned EpochYr  = 1970;

  typedef struct packed {
    logic [4:0] century;
    logic [6:0] year_in_century;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_t;

  // days before the first of each month, year counted from march 1
  function automatic logic [8:0] month_start(input logic [3:0] mi);
    logic [8:0] v;
    case (mi)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd366;
    endcase
    return v;
  endfunction

endpackage

// ===== design/estc_if.sv =====
// estc_if: valid/ready channel carrying a generic payload
// depends on nothing
interface estc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/estc_pipe.sv =====
// estc_pipe: stalling pipeline turning seconds into calendar fields
// depends on estc_pkg
module estc_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [estc_pkg::SecsW-1:0]    in_secs,
  output logic                          out_vld,
  output estc_pkg::cal_t                out_cal
);
  import estc_pkg::*;

  // stage 1: secs -> mins
  logic        v1_r;
  logic [26:0] q1_r;
  logic [5:0]  xlo1_r;
  // stage 2: mins -> hours, second
  logic        v2_r;
  logic [20:0] q2_r;
  logic [5:0]  q1lo2_r, sec2_r;
  // stage 3: hours -> days, minute
  logic        v3_r;
  logic [DaysW-1:0] day3_r;
  logic [4:0]  q2lo3_r;
  logic [5:0]  sec3_r, min3_r;
  // stage 4: hour, days since 1968-03-01 with a phantom feb 29 2100
  logic        v4_r;
  logic [DaysW-1:0] dd4_r;
  logic [4:0]  hr4_r;
  logic [5:0]  sec4_r, min4_r;
  // stage 5: 4-year block number
  logic        v5_r;
  logic [DaysW-1:0] dd5_r;
  logic [5:0]  cyc5_r;
  logic [4:0]  hr5_r;
  logic [5:0]  sec5_r, min5_r;
  // stage 6: day within block
  logic        v6_r;
  logic [5:0]  cyc6_r;
  logic [10:0] r6_r;
  logic [4:0]  hr6_r;
  logic [5:0]  sec6_r, min6_r;
  // stage 7: year offset from 1968 (march based), day of year
  logic        v7_r;
  logic [7:0]  yoff7_r;
  logic [8:0]  doy7_r;
  logic [4:0]  hr7_r;
  logic [5:0]  sec7_r, min7_r;
  // stage 8: month, day, calendar year offset
  logic        v8_r;
  logic [7:0]  yoff8_r;
  logic [3:0]  mon8_r;
  logic [4:0]  dom8_r;
  logic [4:0]  hr8_r;
  logic [5:0]  sec8_r, min8_r;

  logic [60:0] p1;
  logic [26:0] q1;
  logic [50:0] p2;
  logic [20:0] q2;
  logic [36:0] p3;
  logic [DaysW-1:0] q3;
  logic [DaysW-1:0] dm;
  logic [DaysW-1:0] dd;
  logic [32:0] p5;
  logic [5:0]  cyc;
  logic [DaysW-1:0] rfull;
  logic [1:0]  yoc;
  logic [8:0]  doy;
  logic [3:0]  mp;
  logic [3:0]  mon;
  logic [8:0]  dstart;
  logic [7:0]  yoff;

  always_comb begin
    // x/60 = (x>>2)/15, reciprocal exact for x < 2^32
    p1 = {31'd0, in_secs[31:2]} * 61'd1145324613;
    q1 = p1[60:34];
    p2 = {26'd0, q1_r[26:2]} * 51'd35791395;
    q2 = p2[49:29];
    // hours/24 = (hours>>3)/3
    p3 = {19'd0, q2_r[20:3]} * 37'd349526;
    q3 = p3[35:20];
    // 1968-03-01 is 671 days before the epoch; 2100 has no feb 29
    dm = day3_r + 16'd671;
    dd = dm + ((dm >= 16'd48212) ? 16'd1 : 16'd0);
    p5 = {17'd0, dd4_r} * 33'd91868;                 // ceil(2^27/1461)
    cyc = p5[32:27];
    rfull = dd5_r - 16'(cyc5_r) * 16'd1461;
  end

  // year inside block: leap day sits at the very end of the block
  always_comb begin
    if (r6_r < 11'd365) begin
      yoc = 2'd0; doy = r6_r[8:0];
    end else if (r6_r < 11'd730) begin
      yoc = 2'd1; doy = 9'(r6_r - 11'd365);
    end else if (r6_r < 11'd1095) begin
      yoc = 2'd2; doy = 9'(r6_r - 11'd730);
    end else begin
      yoc = 2'd3; doy = 9'(r6_r - 11'd1095);
    end
  end

  always_comb begin
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy7_r >= month_start(4'(k))) mp = 4'(k);
    end
    dstart = month_start(mp);
    // january and february belong to the next calendar year
    mon = (mp >= 4'd10) ? mp - 4'd9 : mp + 4'd3;
    yoff = yoff7_r + ((mp >= 4'd10) ? 8'd1 : 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r <= q1; xlo1_r <= in_secs[5:0];
      q2_r <= q2; q1lo2_r <= q1_r[5:0];
      sec2_r <= 6'(xlo1_r - q1_r[5:0] * 6'd60);
      day3_r <= q3; q2lo3_r <= q2_r[4:0];
      min3_r <= 6'(q1lo2_r - q2_r[5:0] * 6'd60);
      sec3_r <= sec2_r;
      dd4_r <= dd;
      hr4_r <= 5'(q2lo3_r - day3_r[4:0] * 5'd24);
      min4_r <= min3_r; sec4_r <= sec3_r;
      dd5_r <= dd4_r; cyc5_r <= cyc;
      hr5_r <= hr4_r; min5_r <= min4_r; sec5_r <= sec4_r;
      cyc6_r <= cyc5_r; r6_r <= rfull[10:0];
      hr6_r <= hr5_r; min6_r <= min5_r; sec6_r <= sec5_r;
      yoff7_r <= {cyc6_r, yoc}; doy7_r <= doy;
      hr7_r <= hr6_r; min7_r <= min6_r; sec7_r <= sec6_r;
      yoff8_r <= yoff; mon8_r <= mon;
      dom8_r <= 5'(doy7_r - dstart + 9'd1);
      hr8_r <= hr7_r; min8_r <= min7_r; sec8_r <= sec7_r;
    end
  end

  assign out_vld = v8_r;
  always_comb begin
    out_cal.century         = (yoff8_r >= 8'd132) ? 5'd21 :
                              (yoff8_r >= 8'd32)  ? 5'd20 : 5'd19;
    out_cal.year_in_century = (yoff8_r >= 8'd132) ? 7'(yoff8_r - 8'd132) :
                              (yoff8_r >= 8'd32)  ? 7'(yoff8_r - 8'd32) :
                                                    7'(yoff8_r + 8'd68);
    out_cal.month           = mon8_r;
    out_cal.day_of_month    = dom8_r;
    out_cal.hour            = hr8_r;
    out_cal.minute          = min8_r;
    out_cal.second          = sec8_r;
  end

`ifndef SYNTHESIS
  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> sec2_r < 6'd60) else $error("second out of range");
  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> min3_r < 6'd60) else $error("minute out of range");
  a_hr_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> hr4_r < 5'd24) else $error("hour out of range");
  a_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r |-> doy7_r < 9'd366) else $error("day of year out of range");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v8_r)) else $error("valid moved during stall");
`endif
endmodule

// ===== design/epoch_seconds_to_calendar.sv =====
// epoch_seconds_to_calendar: top level, seconds since 1970 to utc calendar fields
// depends on estc_pkg, estc_if and estc_pipe
// Each request passes an eight-stage pipeline (divide by 60, 60 and 24 through reciprocal
// multiplies, shift to days since 1968-03-01 with the 2100 correction, 4-year block split,
// year within block, then a month-table lookup), and a new request may enter every cycle
// unless the result side stalls. The whole pipe holds while the result side stalls, and the
// input is not taken during that time.
module epoch_seconds_to_calendar (
  input  logic clk,
  input  logic rst_n,
  estc_if.sink   in_ch,
  estc_if.source out_ch
);
  import estc_pkg::*;

  logic en;
  logic vld;
  cal_t cal;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  estc_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_ch.valid),
    .in_secs (in_ch.data),
    .out_vld (vld),
    .out_cal (cal)
  );

  assign out_ch.valid = vld;
  assign out_ch.data  = cal;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready) else $error("input blocked with empty output");
  a_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.month >= 4'd1 && out_ch.data.month <= 4'd12)
    else $error("month out of range");
`endif
endmodule
